### sv/epr_pkg.sv
// Package with widths, types and helpers for the extremum-preserving face reconstruction.
package epr_pkg;

    localparam int DataWidth = 32;
    localparam int RhoBits   = 24;
    localparam int WideWidth = 48;
    localparam int DivSteps  = 25;

    typedef logic signed [WideWidth-1:0] wide_t;

    function automatic logic [WideWidth-1:0] mag_w(input wide_t x);
        mag_w = x[WideWidth-1] ? WideWidth'(-x) : WideWidth'(x);
    endfunction

    function automatic logic [1:0] sgn_w(input wide_t x);
        // Bit 1 set for positive, bit 0 set for negative.
        sgn_w = {(x > 0), x[WideWidth-1]};
    endfunction

    // Product of two signs is strictly positive.
    function automatic logic sgn_pos(input wide_t x, input wide_t y);
        sgn_pos = ((x > 0) && (y > 0)) || (x[WideWidth-1] && y[WideWidth-1]);
    endfunction

    // Returns four times the limited curvature.
    function automatic wide_t limit4(input wide_t curv4, input wide_t n1,
                                     input wide_t n2, input wide_t n3);
        logic [WideWidth-1:0] ls;
        logic [WideWidth-1:0] v;
        logic [WideWidth-1:0] ac;
        ls = mag_w(n1);
        if (mag_w(n2) < ls) ls = mag_w(n2);
        if (mag_w(n3) < ls) ls = mag_w(n3);
        ac = mag_w(curv4);
        v  = (ls * 5 < ac) ? WideWidth'(ls * 5) : ac;
        if (curv4 > 0 && n1 > 0 && n2 > 0 && n3 > 0) limit4 = wide_t'(v);
        else if (curv4 < 0 && n1 < 0 && n2 < 0 && n3 < 0) limit4 = -wide_t'(v);
        else limit4 = '0;
    endfunction

    function automatic logic [DataWidth-1:0] sat32(input logic signed [79:0] v);
        if (v > 80'sh7FFFFFFF) sat32 = 32'h7FFF_FFFF;
        else if (v < -80'sh80000000) sat32 = 32'h8000_0000;
        else sat32 = v[DataWidth-1:0];
    endfunction

endpackage

### sv/extremum_preserving_ppm_reconstruct.sv
// Top level: five-sample stencil in, limited left and right face values out.
// Pipeline: 32 register stages from an accepted input beat to its output beat.
// Throughput: one beat per cycle; a stall on m_axis freezes the whole pipeline.
// Stages: face estimates, face limiter, extremum test, tolerance test, 25 restoring
// divide steps for rho, one product stage, one divide-by-24 stage, rounding and saturation.
// Reset: aresetn, synchronous, active low, clears valid bits and tol_reg.
module extremum_preserving_ppm_reconstruct
    import epr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_m2, sample_m1, sample_center, sample_p1, sample_p2 from bit 0 up
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // right_face_value, left_face_value from bit 0 up
    output logic [63:0]  m_axis_tdata
);

    localparam int NStage = 7 + DivSteps;

    logic [31:0] tol_reg;
    logic        adv;
    logic [NStage-1:0] vld_reg;

    assign cfg_ready     = 1'b1;
    assign adv           = !vld_reg[NStage-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NStage-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
            vld_reg <= '0;
        end else begin
            if (cfg_valid) tol_reg <= cfg_data;
            if (adv) vld_reg <= {vld_reg[NStage-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: face estimates and second differences.
    wide_t b1_reg, c1_reg, d1_reg, l12_reg, r12_reg, dl_reg, dc_reg, dr_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            wide_t a, b, c, d, e;
            a = wide_t'($signed(s_axis_tdata[31:0]));
            b = wide_t'($signed(s_axis_tdata[63:32]));
            c = wide_t'($signed(s_axis_tdata[95:64]));
            d = wide_t'($signed(s_axis_tdata[127:96]));
            e = wide_t'($signed(s_axis_tdata[159:128]));
            b1_reg  <= b;
            c1_reg  <= c;
            d1_reg  <= d;
            l12_reg <= 7 * (c + b) - (a + d);
            r12_reg <= 7 * (c + d) - (b + e);
            dl_reg  <= a + c - 2 * b;
            dc_reg  <= b + d - 2 * c;
            dr_reg  <= c + e - 2 * d;
        end
    end

    // Stage 2: second-derivative limiter at each face.
    wide_t b2_reg, c2_reg, d2_reg, l24_reg, r24_reg, dl2_reg, dc2_reg, dr2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            b2_reg <= b1_reg; c2_reg <= c1_reg; d2_reg <= d1_reg;
            dl2_reg <= dl_reg; dc2_reg <= dc_reg; dr2_reg <= dr_reg;
            if (sgn_pos(12 * b1_reg - l12_reg, 12 * c1_reg - l12_reg))
                l24_reg <= 12 * (b1_reg + c1_reg)
                    - limit4(2 * (6 * (b1_reg + c1_reg) - l12_reg), dl_reg, dc_reg, dc_reg);
            else
                l24_reg <= 2 * l12_reg;
            if (sgn_pos(12 * c1_reg - r12_reg, 12 * d1_reg - r12_reg))
                r24_reg <= 12 * (c1_reg + d1_reg)
                    - limit4(2 * (6 * (c1_reg + d1_reg) - r12_reg), dc_reg, dr_reg, dr_reg);
            else
                r24_reg <= 2 * r12_reg;
        end
    end

    // Stage 3: extremum test, limited curvature, clamp branch.
    wide_t c3_reg, l3_reg, r3_reg, s3_reg, l4_reg;
    logic  ext3_reg;
    logic [31:0] m3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            wide_t c24, qc, qd;
            logic [WideWidth-1:0] m;
            logic ext;
            c24 = 24 * c2_reg;
            qc  = r24_reg - c24;
            qd  = l24_reg - c24;
            m = mag_w(b2_reg);
            if (mag_w(c2_reg) > m) m = mag_w(c2_reg);
            if (mag_w(d2_reg) > m) m = mag_w(d2_reg);
            ext = !sgn_pos(qc, -qd) || !sgn_pos(b2_reg - c2_reg, c2_reg - d2_reg);
            c3_reg   <= c2_reg;
            m3_reg   <= m[31:0];
            ext3_reg <= ext;
            s3_reg   <= l24_reg + r24_reg - 2 * c24;
            l4_reg   <= limit4(l24_reg + r24_reg - 2 * c24, dc2_reg, dl2_reg, dr2_reg);
            // The overshoot clamp only applies on monotone data.
            r3_reg   <= (!ext && mag_w(qc) >= 2 * mag_w(qd)) ? c24 - 2 * qd : r24_reg;
            l3_reg   <= (!ext && mag_w(qd) >= 2 * mag_w(qc)) ? c24 - 2 * qc : l24_reg;
        end
    end

    // Stage 4: tolerance test (as<<30 against tol*m) and divider set-up.
    logic [WideWidth-1:0] as_reg;
    wide_t c4_reg, dl4_reg, dr4_reg, lo4_reg, ro4_reg;
    logic  ext4_reg, app4_reg;
    logic [WideWidth-1:0] num4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [WideWidth-1:0] as;
            logic [63:0] tm;
            as = mag_w(s3_reg);
            tm = {32'd0, tol_reg} * {32'd0, m3_reg};
            c4_reg   <= c3_reg;
            ext4_reg <= ext3_reg;
            app4_reg <= (as >= 48'h2_0000_0000) || ((64'(as) << 30) > tm);
            as_reg   <= as;
            num4_reg <= mag_w(l4_reg);
            dl4_reg  <= l3_reg - 24 * c3_reg;
            dr4_reg  <= r3_reg - 24 * c3_reg;
            lo4_reg  <= l3_reg;
            ro4_reg  <= r3_reg;
        end
    end

    // Restoring division: |l4| <= |s|, so rho fits 25 bits; one bit per stage.
    logic [WideWidth-1:0] rem_reg [1:DivSteps];
    logic [DivSteps-1:0]  q_reg   [1:DivSteps];
    logic [WideWidth-1:0] dv_reg  [1:DivSteps];
    wide_t                pc_reg  [1:DivSteps];
    wide_t                pl_reg  [1:DivSteps];
    wide_t                pr_reg  [1:DivSteps];
    wide_t                ol_reg  [1:DivSteps];
    wide_t                or_reg  [1:DivSteps];
    logic                 pe_reg  [1:DivSteps];
    logic                 pa_reg  [1:DivSteps];

    always_ff @(posedge aclk) begin
        logic [WideWidth:0] t;
        if (adv) begin
            t = {1'b0, num4_reg};
            if (as_reg != '0 && t >= {1'b0, as_reg}) begin
                rem_reg[1] <= WideWidth'(t - {1'b0, as_reg});
                q_reg[1]   <= DivSteps'(1);
            end else begin
                rem_reg[1] <= num4_reg;
                q_reg[1]   <= '0;
            end
            dv_reg[1] <= as_reg;
            pc_reg[1] <= c4_reg;
            pl_reg[1] <= dl4_reg;
            pr_reg[1] <= dr4_reg;
            ol_reg[1] <= lo4_reg;
            or_reg[1] <= ro4_reg;
            pe_reg[1] <= ext4_reg;
            pa_reg[1] <= app4_reg;
            for (int k = 1; k < DivSteps; k++) begin
                t = {rem_reg[k], 1'b0};
                if (dv_reg[k] != '0 && t >= {1'b0, dv_reg[k]}) begin
                    rem_reg[k+1] <= WideWidth'(t - {1'b0, dv_reg[k]});
                    q_reg[k+1]   <= {q_reg[k][DivSteps-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= t[WideWidth-1:0];
                    q_reg[k+1]   <= {q_reg[k][DivSteps-2:0], 1'b0};
                end
                dv_reg[k+1] <= dv_reg[k];
                pc_reg[k+1] <= pc_reg[k];
                pl_reg[k+1] <= pl_reg[k];
                pr_reg[k+1] <= pr_reg[k];
                ol_reg[k+1] <= ol_reg[k];
                or_reg[k+1] <= or_reg[k];
                pe_reg[k+1] <= pe_reg[k];
                pa_reg[k+1] <= pa_reg[k];
            end
        end
    end

    // Product stage: dev24 * rho plus half; deviations stay within 40 signed bits.
    logic signed [79:0] pl6_reg, pr6_reg, ql6_reg, qr6_reg;
    wide_t c6_reg;
    logic  e6_reg, a6_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [25:0] rho;
            logic signed [39:0] devl, devr;
            logic signed [65:0] prl, prr;
            rho  = $signed({1'b0, q_reg[DivSteps]});
            devl = pl_reg[DivSteps][39:0];
            devr = pr_reg[DivSteps][39:0];
            prl  = devl * rho;
            prr  = devr * rho;
            pl6_reg <= 80'(prl) + (80'sd12 <<< RhoBits);
            pr6_reg <= 80'(prr) + (80'sd12 <<< RhoBits);
            ql6_reg <= 80'(ol_reg[DivSteps]) + 80'sd12;
            qr6_reg <= 80'(or_reg[DivSteps]) + 80'sd12;
            c6_reg  <= pc_reg[DivSteps];
            e6_reg  <= pe_reg[DivSteps];
            a6_reg  <= pa_reg[DivSteps];
        end
    end

    // Floor division by 3 of a value below 2^37 in magnitude. A bias of 3*2^38 makes it
    // non-negative; the upper half is folded in as 2^20 = 3*349525 + 1, and the
    // remaining 21-bit sum is divided by a reciprocal multiplication.
    function automatic logic signed [79:0] fdiv3(input logic signed [79:0] n);
        logic [39:0] u;
        logic [19:0] uh;
        logic [19:0] ul;
        logic [20:0] w;
        logic [42:0] wm;
        logic [39:0] q;
        u  = 40'(n + (80'sd3 <<< 38));
        uh = u[39:20];
        ul = u[19:0];
        w  = {1'b0, uh} + {1'b0, ul};
        wm = 43'(w) * 43'd1398102;
        q  = 40'(uh) * 40'd349525 + 40'(wm[42:22]);
        fdiv3 = $signed(80'(q)) - (80'sd1 <<< 38);
    endfunction

    // Floor division by 24: floor(floor(n/8)/3) equals floor(n/24).
    logic signed [79:0] fl7_reg, fr7_reg;
    logic signed [79:0] c7_reg;
    logic  e7_reg, a7_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            fl7_reg <= e6_reg ? fdiv3(pl6_reg >>> (RhoBits + 3)) : fdiv3(ql6_reg >>> 3);
            fr7_reg <= e6_reg ? fdiv3(pr6_reg >>> (RhoBits + 3)) : fdiv3(qr6_reg >>> 3);
            c7_reg  <= 80'(c6_reg);
            e7_reg  <= e6_reg;
            a7_reg  <= a6_reg;
        end
    end

    logic [63:0] out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (!e7_reg) out_reg <= {sat32(fl7_reg), sat32(fr7_reg)};
            else if (a7_reg)
                out_reg <= {sat32(c7_reg + fl7_reg), sat32(c7_reg + fr7_reg)};
            else
                out_reg <= {sat32(c7_reg), sat32(c7_reg)};
        end
    end
    assign m_axis_tdata = out_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule
